@@ sv/dcr_pkg.sv @@
// shared types, register codes and constants of the depth to colour registration block
`default_nettype none
package dcr_pkg;

  localparam int COLOR_WIDTH_DEF    = 1280;
  localparam int COLOR_HEIGHT_DEF   = 720;
  localparam int SUBSAMPLE_STEP_DEF = 2;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RAW_SCALE    = 4'd0,
    CFG_DEPTH_FOCAL  = 4'd1,
    CFG_DEPTH_CENTER = 4'd2,
    CFG_COLOR_FOCAL  = 4'd3,
    CFG_COLOR_CENTER = 4'd4,
    CFG_ROTATION_XY  = 4'd5,
    CFG_ROTATION_ZW  = 4'd6,
    CFG_TRANSLATION  = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] raw_scale;
    logic [63:0] depth_focal;
    logic [63:0] depth_center;
    logic [63:0] color_focal;
    logic [63:0] color_center;
    logic [63:0] rotation_xy;
    logic [63:0] rotation_zw;
    logic [62:0] translation;
  } cfg_t;

  typedef logic [8:0][31:0] rot_mat_t;

  localparam logic [31:0] RAW_SCALE_RST   = 32'd4294967;
  localparam logic [63:0] ROTATION_ZW_RST = 64'h4000_0000_0000_0000;

  localparam logic [47:0]        MAX_DEPTH_Q32 = 48'h000A_0000_0000;
  localparam logic signed [31:0] Z_MIN_LSB     = 32'sd65;
  localparam logic signed [36:0] ONE_Q30       = 37'sd1073741824;
  localparam logic signed [37:0] HALF_PIXEL    = 38'sd32768;
  localparam logic signed [37:0] MINUS_PIXEL   = -38'sd65536;

endpackage
`default_nettype wire

@@ sv/dcr_pixel_if.sv @@
// depth pixel channel
`default_nettype none
interface dcr_pixel_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_col;
  logic [11:0] pixel_row;
  logic [15:0] depth_raw;

  modport source(output valid, output pixel_col, output pixel_row, output depth_raw,
                 input ready);
  modport sink(input valid, input pixel_col, input pixel_row, input depth_raw,
               output ready);
endinterface
`default_nettype wire

@@ sv/dcr_point_if.sv @@
// registered point channel
`default_nettype none
interface dcr_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [11:0]        color_col;
  logic [11:0]        color_row;

  modport source(output valid, output point_x, output point_y, output point_z,
                 output color_col, output color_row, input ready);
  modport sink(input valid, input point_x, input point_y, input point_z,
               input color_col, input color_row, output ready);
endinterface
`default_nettype wire

@@ sv/dcr_cfg_regs.sv @@
// configuration register file
`default_nettype none
module dcr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  dcr_pkg::cfg_idx_t                   index,
  input  logic [dcr_pkg::CFG_DATA_W-1:0]      data,
  output dcr_pkg::cfg_t                       cfg
);
  import dcr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_scale    <= RAW_SCALE_RST;
      cfg.depth_focal  <= '0;
      cfg.depth_center <= '0;
      cfg.color_focal  <= '0;
      cfg.color_center <= '0;
      cfg.rotation_xy  <= '0;
      cfg.rotation_zw  <= ROTATION_ZW_RST;
      cfg.translation  <= '0;
    end else if (wr_en) begin
      case (index)
        CFG_RAW_SCALE:    cfg.raw_scale    <= data[31:0];
        CFG_DEPTH_FOCAL:  cfg.depth_focal  <= data;
        CFG_DEPTH_CENTER: cfg.depth_center <= data;
        CFG_COLOR_FOCAL:  cfg.color_focal  <= data;
        CFG_COLOR_CENTER: cfg.color_center <= data;
        CFG_ROTATION_XY:  cfg.rotation_xy  <= data;
        CFG_ROTATION_ZW:  cfg.rotation_zw  <= data;
        CFG_TRANSLATION:  cfg.translation  <= data[62:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/dcr_rot_matrix.sv @@
// rotation matrix from the quaternion registers, two register stages
`default_nettype none
module dcr_rot_matrix (
  input  logic              clk,
  input  logic [63:0]       rotation_xy,
  input  logic [63:0]       rotation_zw,
  output dcr_pkg::rot_mat_t mat
);
  import dcr_pkg::*;

  logic signed [31:0] qx, qy, qz, qw;
  logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
  logic signed [36:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;

  function automatic logic [31:0] clamp_unit(input logic signed [36:0] v);
    if (v > ONE_Q30) begin
      return 32'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      return 32'(-ONE_Q30);
    end
    return v[31:0];
  endfunction

  assign qx = signed'(rotation_xy[31:0]);
  assign qy = signed'(rotation_xy[63:32]);
  assign qz = signed'(rotation_zw[31:0]);
  assign qw = signed'(rotation_zw[63:32]);

  always_ff @(posedge clk) begin
    pxx <= 64'(qx) * 64'(qx);
    pyy <= 64'(qy) * 64'(qy);
    pzz <= 64'(qz) * 64'(qz);
    pxy <= 64'(qx) * 64'(qy);
    pxz <= 64'(qx) * 64'(qz);
    pyz <= 64'(qy) * 64'(qz);
    pxw <= 64'(qx) * 64'(qw);
    pyw <= 64'(qy) * 64'(qw);
    pzw <= 64'(qz) * 64'(qw);
  end

  // floor to q7.30
  assign xx = 37'($signed(pxx[63:30]));
  assign yy = 37'($signed(pyy[63:30]));
  assign zz = 37'($signed(pzz[63:30]));
  assign xy = 37'($signed(pxy[63:30]));
  assign xz = 37'($signed(pxz[63:30]));
  assign yz = 37'($signed(pyz[63:30]));
  assign xw = 37'($signed(pxw[63:30]));
  assign yw = 37'($signed(pyw[63:30]));
  assign zw = 37'($signed(pzw[63:30]));

  always_ff @(posedge clk) begin
    mat[0] <= clamp_unit(ONE_Q30 - ((yy + zz) <<< 1));
    mat[1] <= clamp_unit((xy - zw) <<< 1);
    mat[2] <= clamp_unit((xz + yw) <<< 1);
    mat[3] <= clamp_unit((xy + zw) <<< 1);
    mat[4] <= clamp_unit(ONE_Q30 - ((xx + zz) <<< 1));
    mat[5] <= clamp_unit((yz - xw) <<< 1);
    mat[6] <= clamp_unit((xz - yw) <<< 1);
    mat[7] <= clamp_unit((yz + xw) <<< 1);
    mat[8] <= clamp_unit(ONE_Q30 - ((xx + yy) <<< 1));
  end
endmodule
`default_nettype wire

@@ sv/dcr_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag and sideband
`default_nettype none
module dcr_divider #(
  parameter int NUM_W  = 53,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);
  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [W-1:0]      rem  [1:Q_W-1];
  logic [DEN_W-1:0]  dv   [1:Q_W-1];
  logic [Q_W-1:0]    quo  [1:Q_W];
  logic              vld  [1:Q_W];
  logic              ovfl [1:Q_W];
  logic [SIDE_W-1:0] sd   [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [W-1:0]      p_rem;
    logic [DEN_W-1:0]  p_den;
    logic [Q_W-1:0]    p_quo;
    logic              p_vld;
    logic              p_ovf;
    logic [SIDE_W-1:0] p_sd;
    logic [W-1:0]      sh;
    logic              ge;
    logic [Q_W-1:0]    qn;

    if (k == 0) begin : g_first
      assign p_rem = W'(num);
      assign p_den = den;
      assign p_quo = '0;
      assign p_vld = in_valid;
      assign p_ovf = (W+1)'(num) >= ((W+1)'(den) << Q_W);
      assign p_sd  = side;
    end else begin : g_next
      assign p_rem = rem[k];
      assign p_den = dv[k];
      assign p_quo = quo[k];
      assign p_vld = vld[k];
      assign p_ovf = ovfl[k];
      assign p_sd  = sd[k];
    end

    assign sh = W'(p_den) << B;
    assign ge = p_rem >= sh;

    always_comb begin
      qn    = p_quo;
      qn[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1]  <= qn;
        ovfl[k+1] <= p_ovf;
        sd[k+1]   <= p_sd;
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? p_rem - sh : p_rem;
          dv[k+1]  <= p_den;
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = quo[Q_W];
  assign ovf       = ovfl[Q_W];
  assign side_out  = sd[Q_W];
endmodule
`default_nettype wire

@@ sv/depth_to_color_point_registration_top.sv @@
// depth pixel to colour frame point registration, top level pipeline
// path of a pixel: stages 1-3, depth dividers, stages 4-9, projection dividers, stages 10-11, output register
// throughput: one pixel per cycle unless the output stalls; the dividers are 32 and 34 stage pipelines
// a stall on the output freezes every stage at once; dropped pixels leave bubbles
// reset clears all valid bits and loads the register defaults (identity rotation)
// the rotation matrix follows a quaternion write through the product and matrix registers
`default_nettype none
module depth_to_color_point_registration_top #(
  parameter int COLOR_WIDTH    = dcr_pkg::COLOR_WIDTH_DEF,
  parameter int COLOR_HEIGHT   = dcr_pkg::COLOR_HEIGHT_DEF,
  parameter int SUBSAMPLE_STEP = dcr_pkg::SUBSAMPLE_STEP_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  dcr_pixel_if.sink                         pixel,
  dcr_point_if.source                       point,
  input  logic                              cfg_wr_en,
  input  logic [dcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dcr_pkg::*;

  cfg_t     cfg;
  rot_mat_t mat;
  logic     adv;

  logic signed [31:0] m_e [9];

  dcr_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_idx_t'(cfg_index)),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  dcr_rot_matrix u_rot (
    .clk         (clk),
    .rotation_xy (cfg.rotation_xy),
    .rotation_zw (cfg.rotation_zw),
    .mat         (mat)
  );

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_e[k] = signed'(mat[k]);
    end
  end

  assign adv         = !point.valid || point.ready;
  assign pixel.ready = adv;

  function automatic logic [31:0] sat_deproj(input logic neg, input logic [31:0] q,
                                             input logic of);
    if (neg) begin
      return (of || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
    end
    return (of || q[31]) ? 32'h7FFF_FFFF : q;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic coord_ok(input logic signed [37:0] v, input int limit);
    logic [21:0] i;
    i = (v >= 0) ? v[37:16] : '0;
    return (v > MINUS_PIXEL) && (32'(i) < limit);
  endfunction

  // stage 1: grid test and depth scaling
  localparam int STEP_RECIP = ((1 << 20) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;

  logic        s1_valid;
  logic [47:0] s1_prod;
  logic [11:0] s1_col, s1_row;
  logic        on_grid;
  logic [31:0] col_mul, row_mul;
  logic [15:0] col_back, row_back;

  // quotient by reciprocal multiplication, exact for 12-bit coordinates
  assign col_mul  = 32'(pixel.pixel_col) * 32'(STEP_RECIP);
  assign row_mul  = 32'(pixel.pixel_row) * 32'(STEP_RECIP);
  assign col_back = 16'(col_mul[31:20]) * 16'(SUBSAMPLE_STEP);
  assign row_back = 16'(row_mul[31:20]) * 16'(SUBSAMPLE_STEP);
  assign on_grid  = (col_back == 16'(pixel.pixel_col)) &&
                    (row_back == 16'(pixel.pixel_row));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixel.valid && on_grid && (pixel.depth_raw != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod <= 48'(pixel.depth_raw) * 48'(cfg.raw_scale);
      s1_col  <= pixel.pixel_col;
      s1_row  <= pixel.pixel_row;
    end
  end

  // stage 2: depth range and depth focal tests, pixel offsets from the depth centre
  logic        s2_valid;
  logic [19:0] s2_depth;
  logic [32:0] s2_xmag, s2_ymag;
  logic        s2_xneg, s2_yneg;
  logic [32:0] xa, xb, ya, yb;
  logic        x_ge, y_ge;

  assign xa   = {5'b0, s1_col, 16'b0};
  assign xb   = {1'b0, cfg.depth_center[31:0]};
  assign ya   = {5'b0, s1_row, 16'b0};
  assign yb   = {1'b0, cfg.depth_center[63:32]};
  assign x_ge = xa >= xb;
  assign y_ge = ya >= yb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_prod <= MAX_DEPTH_Q32) &&
                  (cfg.depth_focal[31:0] != '0) && (cfg.depth_focal[63:32] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_depth <= s1_prod[35:16];
      s2_xmag  <= x_ge ? xa - xb : xb - xa;
      s2_ymag  <= y_ge ? ya - yb : yb - ya;
      s2_xneg  <= !x_ge;
      s2_yneg  <= !y_ge;
    end
  end

  // stage 3: numerators of the deprojection
  logic        s3_valid;
  logic [52:0] s3_xnum, s3_ynum;
  logic [19:0] s3_depth;
  logic        s3_xneg, s3_yneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_xnum  <= 53'(s2_xmag) * 53'(s2_depth);
      s3_ynum  <= 53'(s2_ymag) * 53'(s2_depth);
      s3_depth <= s2_depth;
      s3_xneg  <= s2_xneg;
      s3_yneg  <= s2_yneg;
    end
  end

  logic        dx_valid, dy_valid, dx_ovf, dy_ovf;
  logic [31:0] dx_q, dy_q;
  logic [0:0]  dx_side;
  logic [20:0] dy_side;

  dcr_divider #(.NUM_W(53), .DEN_W(32), .Q_W(32), .SIDE_W(1)) u_div_dx (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_valid),
    .num       (s3_xnum),
    .den       (cfg.depth_focal[31:0]),
    .side      (s3_xneg),
    .out_valid (dx_valid),
    .quot      (dx_q),
    .ovf       (dx_ovf),
    .side_out  (dx_side)
  );

  dcr_divider #(.NUM_W(53), .DEN_W(32), .Q_W(32), .SIDE_W(21)) u_div_dy (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_valid),
    .num       (s3_ynum),
    .den       (cfg.depth_focal[63:32]),
    .side      ({s3_yneg, s3_depth}),
    .out_valid (dy_valid),
    .quot      (dy_q),
    .ovf       (dy_ovf),
    .side_out  (dy_side)
  );

  // stage 4: signed, saturated depth frame point
  logic               s4_valid;
  logic signed [31:0] s4_xd, s4_yd, s4_zd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= dx_valid && dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_xd <= signed'(sat_deproj(dx_side[0], dx_q, dx_ovf));
      s4_yd <= signed'(sat_deproj(dy_side[20], dy_q, dy_ovf));
      s4_zd <= signed'({12'b0, dy_side[19:0]});
    end
  end

  // stages 5 to 7: rotation, translation and the near-point drop
  logic               s5_valid, s6_valid, s7_valid;
  logic signed [63:0] s5_p [9];
  logic signed [65:0] s6_sum [3];
  logic signed [31:0] s7_c [3];
  logic signed [31:0] c_next [3];
  logic signed [20:0] t_e [3];

  assign t_e[0] = signed'(cfg.translation[20:0]);
  assign t_e[1] = signed'(cfg.translation[41:21]);
  assign t_e[2] = signed'(cfg.translation[62:42]);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c_next[r] = sat32(37'($signed(s6_sum[r][65:30])) + 37'(t_e[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid && (c_next[2] > Z_MIN_LSB);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        s5_p[3*r]   <= 64'(s4_xd) * 64'(m_e[3*r]);
        s5_p[3*r+1] <= 64'(s4_yd) * 64'(m_e[3*r+1]);
        s5_p[3*r+2] <= 64'(s4_zd) * 64'(m_e[3*r+2]);
        s6_sum[r]   <= 66'(s5_p[3*r]) + 66'(s5_p[3*r+1]) + 66'(s5_p[3*r+2]);
        s7_c[r]     <= c_next[r];
      end
    end
  end

  // stages 8 and 9: projection numerators
  logic               s8_valid, s9_valid;
  logic [31:0]        s8_xmag, s8_ymag;
  logic               s8_xneg, s8_yneg, s9_xneg, s9_yneg;
  logic signed [31:0] s8_xc, s8_yc, s8_zc, s9_xc, s9_yc, s9_zc;
  logic [63:0]        s9_xnum, s9_ynum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
      s9_valid <= 1'b0;
    end else if (adv) begin
      s8_valid <= s7_valid;
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_xneg <= s7_c[0] < 0;
      s8_yneg <= s7_c[1] < 0;
      s8_xmag <= (s7_c[0] < 0) ? 32'(-s7_c[0]) : 32'(s7_c[0]);
      s8_ymag <= (s7_c[1] < 0) ? 32'(-s7_c[1]) : 32'(s7_c[1]);
      s8_xc   <= s7_c[0];
      s8_yc   <= s7_c[1];
      s8_zc   <= s7_c[2];
      s9_xnum <= 64'(s8_xmag) * 64'(cfg.color_focal[31:0]);
      s9_ynum <= 64'(s8_ymag) * 64'(cfg.color_focal[63:32]);
      s9_xneg <= s8_xneg;
      s9_yneg <= s8_yneg;
      s9_xc   <= s8_xc;
      s9_yc   <= s8_yc;
      s9_zc   <= s8_zc;
    end
  end

  logic        px_valid, py_valid, px_ovf, py_ovf;
  logic [33:0] px_q, py_q;
  logic [64:0] px_side;
  logic [32:0] py_side;

  dcr_divider #(.NUM_W(64), .DEN_W(32), .Q_W(34), .SIDE_W(65)) u_div_px (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s9_valid),
    .num       (s9_xnum),
    .den       (32'(s9_zc)),
    .side      ({s9_xneg, s9_xc, s9_zc}),
    .out_valid (px_valid),
    .quot      (px_q),
    .ovf       (px_ovf),
    .side_out  (px_side)
  );

  dcr_divider #(.NUM_W(64), .DEN_W(32), .Q_W(34), .SIDE_W(33)) u_div_py (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s9_valid),
    .num       (s9_ynum),
    .den       (32'(s9_zc)),
    .side      ({s9_yneg, s9_yc}),
    .out_valid (py_valid),
    .quot      (py_q),
    .ovf       (py_ovf),
    .side_out  (py_side)
  );

  // stages 10 and 11: signed offsets, colour centre and half pixel
  logic               s10_valid, s11_valid;
  logic signed [35:0] s10_su, s10_sv;
  logic signed [37:0] s11_u, s11_v;
  logic signed [31:0] s10_xc, s10_yc, s10_zc, s11_xc, s11_yc, s11_zc;
  logic [34:0]        mu, mv;

  // an overflowed quotient lands outside the image in either direction
  assign mu = px_ovf ? 35'h4_0000_0000 : {1'b0, px_q};
  assign mv = py_ovf ? 35'h4_0000_0000 : {1'b0, py_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
      s11_valid <= 1'b0;
    end else if (adv) begin
      s10_valid <= px_valid && py_valid;
      s11_valid <= s10_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_su <= px_side[64] ? -$signed(36'(mu)) : $signed(36'(mu));
      s10_sv <= py_side[32] ? -$signed(36'(mv)) : $signed(36'(mv));
      s10_xc <= signed'(px_side[63:32]);
      s10_zc <= signed'(px_side[31:0]);
      s10_yc <= signed'(py_side[31:0]);
      s11_u  <= 38'(s10_su) + $signed({6'b0, cfg.color_center[31:0]}) + HALF_PIXEL;
      s11_v  <= 38'(s10_sv) + $signed({6'b0, cfg.color_center[63:32]}) + HALF_PIXEL;
      s11_xc <= s10_xc;
      s11_yc <= s10_yc;
      s11_zc <= s10_zc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (adv) begin
      point.valid <= s11_valid && coord_ok(s11_u, COLOR_WIDTH) &&
                     coord_ok(s11_v, COLOR_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point.point_x   <= s11_xc;
      point.point_y   <= s11_yc;
      point.point_z   <= s11_zc;
      point.color_col <= (s11_u >= 0) ? s11_u[27:16] : '0;
      point.color_row <= (s11_v >= 0) ? s11_v[27:16] : '0;
    end
  end

  a_col_in_image: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (32'(point.color_col) < COLOR_WIDTH) &&
                    (32'(point.color_row) < COLOR_HEIGHT))
    else $error("colour coordinate outside the image");

  a_point_in_front: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> point.point_z > Z_MIN_LSB)
    else $error("point too close to the colour camera");

  a_near_dropped: assert property (@(posedge clk) disable iff (rst)
    s7_valid |-> s7_c[2] > Z_MIN_LSB)
    else $error("near point kept after translation");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s4_valid) && $stable(s4_xd) && $stable(s10_valid))
    else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for the depth to colour point registration block
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dcr_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 90;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [11:0]        col;
    logic [11:0]        row;
  } point_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dcr_pixel_if pix();
  dcr_point_if pt();

  depth_to_color_point_registration_top uut (
    .clk(clk), .rst(rst), .pixel(pix), .point(pt),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the register file
  bit [31:0] scale_q32;
  bit [63:0] dep_focal, dep_center, col_focal, col_center, quat_xy, quat_zw;
  bit [62:0] shift_xyz;

  point_t points_due[$];
  int errors;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_req;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_unit(input longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint back_project(input longint unsigned coord, center, dep, foc);
    longint d;
    longint unsigned q;
    d = longint'(coord << 16) - longint'(center);
    q = (magnitude(d) * dep) / foc;
    if (d < 0) return q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
    return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic longint to_pixel(input longint c, input longint unsigned foc,
                                      input longint z, input longint unsigned center,
                                      input longint lim);
    longint unsigned q;
    longint v, i;
    q = (magnitude(c) * foc) / longint'(z);
    v = (c < 0 ? -longint'(q) : longint'(q)) + longint'(center) + 64'sd32768;
    if (v <= -64'sd65536) return -1;
    i = v >= 0 ? (v >>> 16) : 0;
    return i < lim ? i : -1;
  endfunction

  function automatic bit register_pixel(input logic [11:0] c, r, input logic [15:0] raw,
                                        output point_t p);
    longint unsigned prod, dep;
    longint qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, xw, yw, zw;
    longint m [9];
    longint xd, yd, zd, xc, yc, zc, u, v;
    p = '0;
    if (c % SUBSAMPLE_STEP_DEF != 0 || r % SUBSAMPLE_STEP_DEF != 0) return 0;
    if (raw == 0) return 0;
    prod = longint'(raw) * longint'(scale_q32);
    if (prod > (64'd10 << 32)) return 0;
    if (dep_focal[31:0] == 0 || dep_focal[63:32] == 0) return 0;
    dep = prod >> 16;
    xd = back_project(c, dep_center[31:0], dep, dep_focal[31:0]);
    yd = back_project(r, dep_center[63:32], dep, dep_focal[63:32]);
    zd = longint'(dep);
    qx = longint'($signed(quat_xy[31:0]));
    qy = longint'($signed(quat_xy[63:32]));
    qz = longint'($signed(quat_zw[31:0]));
    qw = longint'($signed(quat_zw[63:32]));
    xx = (qx * qx) >>> 30; yy = (qy * qy) >>> 30; zz = (qz * qz) >>> 30;
    xy = (qx * qy) >>> 30; xz = (qx * qz) >>> 30; yz = (qy * qz) >>> 30;
    xw = (qx * qw) >>> 30; yw = (qy * qw) >>> 30; zw = (qz * qw) >>> 30;
    m[0] = clip_unit(64'sd1073741824 - 2 * (yy + zz));
    m[1] = clip_unit(2 * (xy - zw));
    m[2] = clip_unit(2 * (xz + yw));
    m[3] = clip_unit(2 * (xy + zw));
    m[4] = clip_unit(64'sd1073741824 - 2 * (xx + zz));
    m[5] = clip_unit(2 * (yz - xw));
    m[6] = clip_unit(2 * (xz - yw));
    m[7] = clip_unit(2 * (yz + xw));
    m[8] = clip_unit(64'sd1073741824 - 2 * (xx + yy));
    xc = clip32(((xd * m[0] + yd * m[1] + zd * m[2]) >>> 30)
                + longint'($signed(shift_xyz[20:0])));
    yc = clip32(((xd * m[3] + yd * m[4] + zd * m[5]) >>> 30)
                + longint'($signed(shift_xyz[41:21])));
    zc = clip32(((xd * m[6] + yd * m[7] + zd * m[8]) >>> 30)
                + longint'($signed(shift_xyz[62:42])));
    if (zc <= 65) return 0;
    u = to_pixel(xc, col_focal[31:0], zc, col_center[31:0], COLOR_WIDTH_DEF);
    if (u < 0) return 0;
    v = to_pixel(yc, col_focal[63:32], zc, col_center[63:32], COLOR_HEIGHT_DEF);
    if (v < 0) return 0;
    p.x = xc[31:0];
    p.y = yc[31:0];
    p.z = zc[31:0];
    p.col = u[11:0];
    p.row = v[11:0];
    return 1;
  endfunction

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pt.ready <= 1'b0;
    end else begin
      pt.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input longint want, got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (!rst && pt.valid && pt.ready) begin
      if (points_due.size() == 0) begin
        $display("%0t unexpected beat expected none actual x %0d y %0d z %0d col %0d row %0d",
                 $realtime, pt.point_x, pt.point_y, pt.point_z, pt.color_col, pt.color_row);
        errors++;
      end else begin
        want = points_due.pop_front();
        check_field("point_x", want.x, pt.point_x);
        check_field("point_y", want.y, pt.point_y);
        check_field("point_z", want.z, pt.point_z);
        check_field("color_col", want.col, pt.color_col);
        check_field("color_row", want.row, pt.color_row);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (pt.valid && pt.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [11:0] c, r, input logic [15:0] raw);
    point_t p;
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_col <= c;
    pix.pixel_row <= r;
    pix.depth_raw <= raw;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    if (register_pixel(c, r, raw, p)) points_due.push_back(p);
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_RAW_SCALE:    scale_q32 = value[31:0];
      CFG_DEPTH_FOCAL:  dep_focal = value;
      CFG_DEPTH_CENTER: dep_center = value;
      CFG_COLOR_FOCAL:  col_focal = value;
      CFG_COLOR_CENTER: col_center = value;
      CFG_ROTATION_XY:  quat_xy = value;
      CFG_ROTATION_ZW:  quat_zw = value;
      CFG_TRANSLATION:  shift_xyz = value[62:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [31:0] sc, input logic [63:0] df, dc, cf, cc, rxy,
                            rzw, input logic [62:0] tr);
    drain();
    write_reg(CFG_RAW_SCALE, {32'd0, sc});
    write_reg(CFG_DEPTH_FOCAL, df);
    write_reg(CFG_DEPTH_CENTER, dc);
    write_reg(CFG_COLOR_FOCAL, cf);
    write_reg(CFG_COLOR_CENTER, cc);
    write_reg(CFG_ROTATION_XY, rxy);
    write_reg(CFG_ROTATION_ZW, rzw);
    write_reg(CFG_TRANSLATION, {1'b0, tr});
    cfg_wr_en <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [63:0] pair(input int unsigned hi, lo);
    return {hi[31:0], lo[31:0]};
  endfunction

  task automatic nominal_setup(input logic [31:0] sc, input logic [62:0] tr);
    load_setup(sc, pair(600 << 16, 600 << 16), pair(240 << 16, 320 << 16),
               pair(900 << 16, 900 << 16), pair(360 << 16, 640 << 16),
               64'd0, ROTATION_ZW_RST, tr);
  endtask

  task automatic send_random_pixel();
    if ($urandom_range(99) < 85)
      send_pixel(12'(2 * $urandom_range(0, 700)), 12'(2 * $urandom_range(0, 400)),
                 16'($urandom_range(200, 9000)));
    else
      send_pixel(12'($urandom), 12'($urandom), 16'($urandom));
  endtask

  task automatic test_nominal_geometry();
    nominal_setup(RAW_SCALE_RST, {21'd0, 21'd0, 21'd1638});
    send_pixel(12'd320, 12'd240, 16'd1000);
    send_pixel(12'd0, 12'd0, 16'd1000);
    send_pixel(12'd4094, 12'd4094, 16'd1000);
    send_pixel(12'd4095, 12'd0, 16'd1000);
    send_pixel(12'd1, 12'd0, 16'd1000);
    send_pixel(12'd0, 12'd1, 16'd1000);
    send_pixel(12'd320, 12'd240, 16'd0);
    send_pixel(12'd320, 12'd240, 16'd65535);
    send_pixel(12'd320, 12'd240, 16'd10000);
    send_pixel(12'd320, 12'd240, 16'd10001);
    send_pixel(12'd640, 12'd480, 16'd500);
    send_pixel(12'd100, 12'd400, 16'd300);
    send_pixel(12'd638, 12'd478, 16'd1);
  endtask

  task automatic test_scale_extremes();
    nominal_setup(32'hFFFF_FFFF, {21'd0, 21'd0, 21'd0});
    send_pixel(12'd320, 12'd240, 16'd10);
    send_pixel(12'd330, 12'd250, 16'd1);
    send_pixel(12'd320, 12'd240, 16'd11);
    nominal_setup(32'd0, {21'd65536, 21'h1F_0000, 21'd32768});
    send_pixel(12'd320, 12'd240, 16'd4000);
    send_pixel(12'd0, 12'd0, 16'hFFFF);
    nominal_setup(RAW_SCALE_RST, {21'h1F_FF00, 21'd0, 21'd0});
    send_pixel(12'd320, 12'd240, 16'd200);
    send_pixel(12'd320, 12'd240, 16'd66);
  endtask

  task automatic test_zero_depth_focal();
    load_setup(RAW_SCALE_RST, pair(600 << 16, 0), pair(240 << 16, 320 << 16),
               pair(900 << 16, 900 << 16), pair(360 << 16, 640 << 16),
               64'd0, ROTATION_ZW_RST, 63'd0);
    send_pixel(12'd320, 12'd240, 16'd1000);
    drain();
    write_reg(CFG_DEPTH_FOCAL, pair(0, 600 << 16));
    cfg_wr_en <= 1'b0;
    repeat (3) @(posedge clk);
    send_pixel(12'd320, 12'd240, 16'd1000);
  endtask

  task automatic test_zero_color_focal();
    load_setup(RAW_SCALE_RST, pair(600 << 16, 600 << 16), pair(240 << 16, 320 << 16),
               64'd0, pair(360 << 16, 640 << 16), 64'd0, ROTATION_ZW_RST, 63'd0);
    send_pixel(12'd0, 12'd0, 16'd1500);
    send_pixel(12'd600, 12'd400, 16'd700);
  endtask

  task automatic test_non_unit_rotation();
    load_setup(RAW_SCALE_RST, pair(600 << 16, 600 << 16), pair(240 << 16, 320 << 16),
               pair(900 << 16, 900 << 16), pair(360 << 16, 640 << 16),
               {32'h4000_0000, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
               {21'h0F_FFFF, 21'h10_0000, 21'h0F_FFFF});
    repeat (8) send_random_pixel();
  endtask

  task automatic random_setup(input bit wild);
    int unsigned dfx, dfy;
    if (wild) begin
      load_setup($urandom, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 63'({$urandom, $urandom}));
    end else begin
      dfx = ($urandom_range(450, 750) << 16) | $urandom_range(0, 65535);
      dfy = ($urandom_range(450, 750) << 16) | $urandom_range(0, 65535);
      load_setup($urandom_range(2000000, 9000000), pair(dfy, dfx),
                 pair($urandom_range(200, 280) << 16, $urandom_range(280, 360) << 16),
                 pair($urandom_range(700, 1100) << 16, $urandom_range(700, 1100) << 16),
                 pair($urandom_range(330, 390) << 16, $urandom_range(600, 680) << 16),
                 pair($urandom_range(0, 1 << 27) - (1 << 26),
                      $urandom_range(0, 1 << 27) - (1 << 26)),
                 pair((1 << 30) - $urandom_range(0, 1 << 24),
                      $urandom_range(0, 1 << 27) - (1 << 26)),
                 {21'($urandom_range(0, 13000) - 6500), 21'($urandom_range(0, 13000) - 6500),
                  21'($urandom_range(0, 13000) - 6500)});
    end
  endtask

  task automatic test_random_traffic();
    int idle_modes [4] = '{0, 60, 0, 17};
    int stall_modes [4] = '{0, 0, 60, 17};
    for (int k = 0; k < 4; k++) begin
      for (int s = 0; s < 2; s++) begin
        random_setup(k == 3 && s == 1);
        idle_pct = idle_modes[k];
        stall_pct = stall_modes[k];
        repeat (120) send_random_pixel();
      end
    end
  endtask

  task automatic test_backpressure();
    random_setup(1'b0);
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (200) send_random_pixel();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel_col = '0;
    pix.pixel_row = '0;
    pix.depth_raw = '0;
    pt.ready = 1'b0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    scale_q32 = RAW_SCALE_RST;
    dep_focal = '0;
    dep_center = '0;
    col_focal = '0;
    col_center = '0;
    quat_xy = '0;
    quat_zw = ROTATION_ZW_RST;
    shift_xyz = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_nominal_geometry();
    test_scale_extremes();
    test_zero_depth_focal();
    test_zero_color_focal();
    test_non_unit_rotation();
    test_random_traffic();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
